### hdl/text_console_writer_defines.svh
// Assertion macros for the text console writer checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tcw_pkg.sv
// Shared constants, codes and types for the text console writer.
// No dependencies; used by every module in this folder except tcw_ram.
package tcw_pkg;

	localparam int ROWS       = 10;
	localparam int COLUMNS    = 80;
	localparam int TAB_WIDTH  = 8;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	// cell address, counter that can also hold CELL_COUNT, column, tab phase
	localparam int CELL_W = $clog2(CELL_COUNT);
	localparam int CNT_W  = $clog2(CELL_COUNT + 1);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int TAB_W  = $clog2(TAB_WIDTH);

	// fixed field widths of the ports
	localparam int CHAR_W   = 8;
	localparam int CURSOR_W = 10;
	localparam int CELL_IDX_W = 10;

	// character codes with special handling
	localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

	// operation codes
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_TEXT_ATTRIBUTE = 2'd0;
	localparam logic [7:0] ATTR_RESET = 8'd7;

	// one screen cell: attribute in the high byte, character in the low byte
	typedef struct packed {
		logic [CHAR_W-1:0] attr;
		logic [CHAR_W-1:0] chr;
	} cell_t;

	// request from the sequencer to the screen store
	typedef struct packed {
		logic              we;
		logic [CELL_W-1:0] waddr;
		cell_t             wdata;
		logic [CELL_W-1:0] raddr;
	} mem_req_t;

endpackage

### hdl/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Uses no package; width and depth come from its parameters.
module tcw_ram #(
	parameter int DEPTH = 800,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/tcw_ctrl.sv
// Sequencer for the text console writer: cursor, tab fill, scroll copy,
// clearing pass and result register. Depends on tcw_pkg; drives tcw_ram.
module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CHAR_W-1:0]     attr,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [CELL_IDX_W-1:0] read_cell,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CHAR_W-1:0]     cell_char,
	output logic [CHAR_W-1:0]     cell_attr,
	output logic [CURSOR_W-1:0]   cursor_cell,
	output mem_req_t              mem_req,
	input  cell_t                 mem_rdata
);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_READ   = 8'b0000_0100,
		ST_TAB    = 8'b0000_1000,
		ST_CHECK  = 8'b0001_0000,
		ST_SCROLL = 8'b0010_0000,
		ST_ZERO   = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cur_q;
	logic [COL_W-1:0]   col_q;
	logic [TAB_W-1:0]   tpos_q;
	logic [CNT_W-1:0]   addr_q;
	logic               copy_v_s1;
	logic [CELL_W-1:0]  dst_s1;
	logic [CHAR_W-1:0]  res_char_q;
	logic [CHAR_W-1:0]  res_attr_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic [CHAR_W-1:0]  out_attr_q;
	logic [CURSOR_W-1:0] out_cur_q;

	logic               in_fire;
	logic               out_load;
	logic               read_in_range;
	logic               plain_char;
	logic               col_wrap;
	logic [CNT_W-1:0]   cur_inc;
	logic [COL_W-1:0]   nxt_col;
	logic [TAB_W-1:0]   nxt_tpos;
	logic [CNT_W-1:0]   addr_inc;
	logic               addr_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign read_in_range = (int'(read_cell) < CELL_COUNT);
	assign plain_char    = (char_code != CODE_RETURN) && (char_code != CODE_NEWLINE)
		&& (char_code != CODE_TAB);

	// cursor step after one cell is written
	assign cur_inc  = cur_q + CNT_W'(1);
	assign col_wrap = (col_q == COL_W'(COLUMNS - 1));
	assign nxt_col  = col_wrap ? '0 : col_q + COL_W'(1);
	assign nxt_tpos = (col_wrap || (tpos_q == TAB_W'(TAB_WIDTH - 1))) ? '0
		: tpos_q + TAB_W'(1);

	// shared sweep address for clearing, scroll copy and last-row clear
	assign addr_inc  = addr_q + CNT_W'(1);
	assign addr_last = (addr_q == CNT_W'(CELL_COUNT - 1));

	// steer the single write port and the read port
	always_comb begin
		mem_req       = '0;
		mem_req.waddr = cur_q[CELL_W-1:0];
		mem_req.raddr = addr_q[CELL_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = addr_q[CELL_W-1:0];
			end
			ST_IDLE: begin
				mem_req.raddr = CELL_W'(read_cell);
				if (in_fire && (opcode == OP_PUT) && plain_char) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = '{attr: attr, chr: char_code};
				end
			end
			ST_TAB: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = '{attr: attr, chr: CODE_SPACE};
			end
			ST_SCROLL: begin
				mem_req.we    = copy_v_s1;
				mem_req.waddr = dst_s1;
				mem_req.wdata = mem_rdata;
			end
			ST_ZERO: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = addr_q[CELL_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cur_q     <= '0;
			col_q     <= '0;
			tpos_q    <= '0;
			addr_q    <= '0;
			copy_v_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_inc;
					if (addr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (opcode == OP_READ) begin
							state_q <= read_in_range ? ST_READ : ST_DONE;
						end else begin
							case (char_code)
								CODE_RETURN: state_q <= ST_DONE;
								CODE_NEWLINE: begin
									cur_q   <= cur_q + CNT_W'(COLUMNS) - CNT_W'(col_q);
									col_q   <= '0;
									tpos_q  <= '0;
									state_q <= ST_CHECK;
								end
								CODE_TAB: state_q <= ST_TAB;
								default: begin
									cur_q   <= cur_inc;
									col_q   <= nxt_col;
									tpos_q  <= nxt_tpos;
									state_q <= ST_CHECK;
								end
							endcase
						end
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_TAB: begin
					cur_q  <= cur_inc;
					col_q  <= nxt_col;
					tpos_q <= nxt_tpos;
					if (nxt_tpos == '0) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (cur_q >= CNT_W'(CELL_COUNT)) begin
						cur_q     <= cur_q - CNT_W'(COLUMNS);
						addr_q    <= CNT_W'(COLUMNS);
						copy_v_s1 <= 1'b0;
						state_q   <= ST_SCROLL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SCROLL: begin
					// read one row below, write it back a row up in the following cycle
					if (addr_q < CNT_W'(CELL_COUNT)) begin
						addr_q    <= addr_inc;
						copy_v_s1 <= 1'b1;
					end else begin
						addr_q    <= CNT_W'(CELL_COUNT - COLUMNS);
						copy_v_s1 <= 1'b0;
						state_q   <= ST_ZERO;
					end
				end
				ST_ZERO: begin
					addr_q <= addr_inc;
					if (addr_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// copy destination and read result
	always_ff @(posedge clk) begin
		dst_s1 <= CELL_W'(addr_q - CNT_W'(COLUMNS));
		if (in_fire) begin
			res_char_q <= '0;
			res_attr_q <= '0;
		end else if (state_q == ST_READ) begin
			res_char_q <= mem_rdata.chr;
			res_attr_q <= mem_rdata.attr;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= res_char_q;
			out_attr_q <= res_attr_q;
			out_cur_q  <= CURSOR_W'(cur_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_char   = out_char_q;
	assign cell_attr   = out_attr_q;
	assign cursor_cell = out_cur_q;

endmodule

### hdl/text_console_writer.sv
// Text console writer top level: APB attribute register, sequencer, screen store.
// Depends on tcw_pkg, tcw_ctrl and tcw_ram.
//
// A ROWS x COLUMNS character-cell screen (10 x 80) with a cursor. Each input
// transaction is either a put (opcode 0) or a read of one cell (opcode 1) and
// yields exactly one result transaction carrying the cursor afterwards. After
// reset the block runs a pass that clears the screen store before in_ready
// first rises; APB writes are taken during it. The store has one write port and
// one registered read port, which set the path through the states: a read of an
// on-screen cell passes through a read state, a plain character or a newline
// through a scroll check, a carriage return or a read past the last cell goes
// straight to the result, and a tab writes spaces (1 to 8) before the check.
// A put that runs past the last row scrolls, moving nine rows up one cell per
// cycle and clearing the last row. The block takes one transaction at a time;
// a finished result waits in the output register while the next transaction is
// accepted, and a result still waiting there holds the next finished one, and
// in_ready with it, until it is taken.
module text_console_writer
	import tcw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [1:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [CELL_IDX_W-1:0] read_cell,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CHAR_W-1:0]     cell_char,
	output logic [CHAR_W-1:0]     cell_attr,
	output logic [CURSOR_W-1:0]   cursor_cell
);

	logic [CHAR_W-1:0] attr_q;
	logic              reg_sel;
	mem_req_t          mem_req;
	cell_t             mem_rdata;

	// a single register decodes at word index zero, which every two-bit paddr maps to
	assign reg_sel = ((paddr >> 2) == REG_TEXT_ATTRIBUTE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {24'd0, attr_q} : 32'd0;

	// attribute register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			attr_q <= pwdata[CHAR_W-1:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.attr        (attr_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.char_code   (char_code),
		.read_cell   (read_cell),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_char   (cell_char),
		.cell_attr   (cell_attr),
		.cursor_cell (cursor_cell),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	tcw_ram #(
		.DEPTH (CELL_COUNT),
		.WIDTH ($bits(cell_t))
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule

### hdl/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and the macros in text_console_writer_defines.svh.
`include "text_console_writer_defines.svh"

module tcw_checker
	import tcw_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [CURSOR_W-1:0] cursor_cell
);

	// hold a stalled result transaction
	`TCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`TCW_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(cursor_cell), "cursor changed while stalled")

	// accepting a transaction drops in_ready, so none is accepted back to back
	`TCW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted back to back")

	// the reported cursor always lies on the screen
	`TCW_ASSERT_NOW(a_cursor_range, out_valid, int'(cursor_cell) < CELL_COUNT, "cursor off screen")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.cursor_cell (cursor_cell)
);
